// ----- hw/rtl/sfs_pkg.sv -----
// shared constants, codes and helper functions for the scale factor select unit
// used by every module under hw/rtl except sfs_lane
package sfs_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int NUM_SAMPLES     = 12;
    localparam int MAX_SUBBANDS    = 32;
    localparam int SUBBAND_BITS    = 5;
    localparam int COUNT_BITS      = 6;
    localparam int SF_BITS         = 6;

    localparam logic [COUNT_BITS-1:0] SUBBAND_COUNT_RESET = 6'd32;

    // index of an all-zero granule
    localparam logic [SF_BITS-1:0] SF_SILENT = 6'd63;
    localparam logic [SF_BITS-1:0] SF_LOUDEST = 6'd0;

    // highest msb position that still has a table entry: 2^21 sits at index 0
    localparam int TOP_MSB  = 20;
    localparam int THR_BITS = 22;

    // second and third entry of each octave of the threshold table,
    // later octaves are these shifted right (2^(-1/3) and 2^(-2/3) steps)
    localparam logic [THR_BITS-1:0] THR_STEP_1 = 22'd1664510;
    localparam logic [THR_BITS-1:0] THR_STEP_2 = 22'd1321122;

    typedef enum logic [1:0] {
        GRN_FIRST  = 2'd0,
        GRN_SECOND = 2'd1,
        GRN_THIRD  = 2'd2
    } granule_t;

    typedef enum logic [1:0] {
        SEL_ALL       = 2'd0,
        SEL_FIRST_TWO = 2'd1,
        SEL_ONE       = 2'd2,
        SEL_LAST_TWO  = 2'd3
    } sel_code_t;

    typedef enum logic [2:0] {
        CLS_DOWN_FAR  = 3'd0,
        CLS_DOWN_NEAR = 3'd1,
        CLS_EQUAL     = 3'd2,
        CLS_UP_NEAR   = 3'd3,
        CLS_UP_FAR    = 3'd4
    } diff_class_t;

    // class of the step from index a to index b
    function automatic diff_class_t diff_class(input logic [SF_BITS-1:0] a,
                                               input logic [SF_BITS-1:0] b);
        logic signed [SF_BITS:0] d;
        diff_class_t c;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        if (d <= -3) begin
            c = CLS_DOWN_FAR;
        end else if (d < 0) begin
            c = CLS_DOWN_NEAR;
        end else if (d == 0) begin
            c = CLS_EQUAL;
        end else if (d < 3) begin
            c = CLS_UP_NEAR;
        end else begin
            c = CLS_UP_FAR;
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/sfs_lane.sv -----
// one sample lane: registered magnitude of a two's complement sample
// depends on nothing but its parameter
module sfs_lane #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          load,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic        [SAMPLE_BITS-1:0] mag
);

    logic [SAMPLE_BITS-1:0] mag_reg;
    logic [SAMPLE_BITS-1:0] mag_next;

    // the most negative value maps to 2^(SAMPLE_BITS-1), which still fits unsigned
    always_comb begin
        if (sample[SAMPLE_BITS-1]) begin
            mag_next = SAMPLE_BITS'(-sample);
        end else begin
            mag_next = SAMPLE_BITS'(sample);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mag_reg <= mag_next;
        end
    end

    assign mag = mag_reg;

endmodule

// ----- hw/rtl/sfs_max_merge.sv -----
// merge stage: largest of the lane magnitudes, one registered result per transfer
// depends on sfs_pkg
module sfs_max_merge #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] mag [sfs_pkg::NUM_SAMPLES],
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] vmax
);

    logic                   valid_reg;
    logic                   valid_next;
    logic [SAMPLE_BITS-1:0] vmax_reg;
    logic [SAMPLE_BITS-1:0] vmax_next;
    logic [SAMPLE_BITS-1:0] lvl1 [6];
    logic [SAMPLE_BITS-1:0] lvl2 [3];
    logic [SAMPLE_BITS-1:0] lvl3;

    // 12 -> 6 -> 3 -> 2 -> 1 compare tree
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            lvl1[i] = (mag[2*i] > mag[2*i+1]) ? mag[2*i] : mag[2*i+1];
        end
        for (int i = 0; i < 3; i++) begin
            lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
        end
        lvl3      = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
        vmax_next = (lvl3 > lvl2[2]) ? lvl3 : lvl2[2];
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            vmax_reg <= vmax_next;
        end
    end

    assign out_valid = valid_reg;
    assign vmax      = vmax_reg;

endmodule

// ----- hw/rtl/sfs_index.sv -----
// index stage: scale factor index of one granule from its largest magnitude
// depends on sfs_pkg
module sfs_index #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [SAMPLE_BITS-1:0]      vmax,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sfs_pkg::SF_BITS-1:0] idx
);

    localparam int CMP_BITS = (SAMPLE_BITS > sfs_pkg::THR_BITS) ? SAMPLE_BITS
                                                                 : sfs_pkg::THR_BITS;

    logic                        valid_reg;
    logic                        valid_next;
    logic [sfs_pkg::SF_BITS-1:0] idx_reg;
    logic [sfs_pkg::SF_BITS-1:0] idx_next;
    logic [4:0]                  msb_pos;
    logic [4:0]                  shift;
    logic [sfs_pkg::THR_BITS-1:0] thr_1;
    logic [sfs_pkg::THR_BITS-1:0] thr_2;
    logic [sfs_pkg::THR_BITS-1:0] thr_3;
    logic [CMP_BITS-1:0]         v_cmp;
    logic [1:0]                  steps;
    logic [sfs_pkg::SF_BITS-1:0] base;

    always_comb begin
        msb_pos = '0;
        for (int i = 0; i < SAMPLE_BITS; i++) begin
            if (vmax[i]) begin
                msb_pos = 5'(i);
            end
        end
        // the guess lands on the entry equal to 2^(msb+1); the next three
        // entries of the table are the only ones that can still be reached
        shift = 5'(sfs_pkg::TOP_MSB) - msb_pos;
        base  = sfs_pkg::SF_BITS'(3 * (sfs_pkg::TOP_MSB - int'(msb_pos)));
        thr_1 = sfs_pkg::THR_STEP_1 >> shift;
        thr_2 = sfs_pkg::THR_STEP_2 >> shift;
        thr_3 = sfs_pkg::THR_BITS'(1) << msb_pos;
        v_cmp = CMP_BITS'(vmax);
        // thresholds fall monotonically, so counting hits equals walking the table
        steps = {1'b0, v_cmp <= CMP_BITS'(thr_1)}
              + {1'b0, v_cmp <= CMP_BITS'(thr_2)}
              + {1'b0, v_cmp <= CMP_BITS'(thr_3)};
        if (vmax == '0) begin
            idx_next = sfs_pkg::SF_SILENT;
        end else if (msb_pos > 5'(sfs_pkg::TOP_MSB)) begin
            idx_next = sfs_pkg::SF_LOUDEST;
        end else begin
            idx_next = base + sfs_pkg::SF_BITS'(steps);
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            idx_reg <= idx_next;
        end
    end

    assign out_valid = valid_reg;
    assign idx       = idx_reg;

endmodule

// ----- hw/rtl/sfs_pattern.sv -----
// pattern stage: collects three granule indices, picks the transmission pattern,
// counts subbands and holds the result register; depends on sfs_pkg
module sfs_pattern (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [sfs_pkg::COUNT_BITS-1:0]   cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sfs_pkg::SF_BITS-1:0]      idx,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sfs_pkg::SUBBAND_BITS-1:0] m_subband,
    output logic [sfs_pkg::SF_BITS-1:0]      m_sf_first,
    output logic [sfs_pkg::SF_BITS-1:0]      m_sf_second,
    output logic [sfs_pkg::SF_BITS-1:0]      m_sf_third,
    output logic [1:0]                       m_select_code,
    output logic                             m_last_subband
);

    localparam logic [sfs_pkg::COUNT_BITS-1:0] MAX_COUNT =
        sfs_pkg::COUNT_BITS'(sfs_pkg::MAX_SUBBANDS);

    sfs_pkg::granule_t                granule_reg, granule_next;
    logic [sfs_pkg::SF_BITS-1:0]      held_a_reg, held_a_next;
    logic [sfs_pkg::SF_BITS-1:0]      held_b_reg, held_b_next;
    logic [sfs_pkg::SUBBAND_BITS-1:0] counter_reg, counter_next;
    logic [sfs_pkg::COUNT_BITS-1:0]   count_reg, count_next;
    logic                             m_valid_reg, m_valid_next;
    logic [sfs_pkg::SUBBAND_BITS-1:0] subband_reg, subband_next;
    logic [sfs_pkg::SF_BITS-1:0]      sf0_reg, sf0_next;
    logic [sfs_pkg::SF_BITS-1:0]      sf1_reg, sf1_next;
    logic [sfs_pkg::SF_BITS-1:0]      sf2_reg, sf2_next;
    sfs_pkg::sel_code_t               code_reg, code_next;
    logic                             last_reg, last_next;

    sfs_pkg::diff_class_t             d1;
    sfs_pkg::diff_class_t             d2;
    logic [4:0]                       rule;
    logic [sfs_pkg::SF_BITS-1:0]      s0, s1, s2;
    sfs_pkg::sel_code_t               code;
    logic [sfs_pkg::COUNT_BITS-1:0]   eff_count;
    logic                             last;
    logic                             emits;
    logic                             fire;

    // pattern rule over the class pair, held indices are granules 0 and 1
    always_comb begin
        d1   = sfs_pkg::diff_class(held_a_reg, held_b_reg);
        d2   = sfs_pkg::diff_class(held_b_reg, idx);
        rule = 5'(d1) * 5'd5 + 5'(d2);
        s0   = held_a_reg;
        s1   = held_b_reg;
        s2   = idx;
        code = sfs_pkg::SEL_ALL;
        case (rule) inside
            5'd1, 5'd2, 5'd21, 5'd22: begin
                code = sfs_pkg::SEL_LAST_TWO;
                s2   = held_b_reg;
            end
            5'd3, 5'd23: begin
                code = sfs_pkg::SEL_LAST_TWO;
                s1   = idx;
            end
            5'd5, 5'd9, 5'd14: begin
                code = sfs_pkg::SEL_FIRST_TWO;
                s1   = held_a_reg;
            end
            5'd6, 5'd7, 5'd10, 5'd11, 5'd12: begin
                code = sfs_pkg::SEL_ONE;
                s1   = held_a_reg;
                s2   = held_a_reg;
            end
            5'd13, 5'd18: begin
                code = sfs_pkg::SEL_ONE;
                s0   = idx;
                s1   = idx;
            end
            5'd15, 5'd16, 5'd17: begin
                code = sfs_pkg::SEL_ONE;
                s0   = held_b_reg;
                s2   = held_b_reg;
            end
            5'd8: begin
                // small step down then small step up: keep the smaller end
                code = sfs_pkg::SEL_ONE;
                if (held_a_reg > idx) begin
                    s0 = idx;
                end
                s1 = s0;
                s2 = s0;
            end
            default: begin
                code = sfs_pkg::SEL_ALL;
            end
        endcase
    end

    // a count of zero or past the limit means all subbands
    always_comb begin
        if (count_reg == '0 || count_reg > MAX_COUNT) begin
            eff_count = MAX_COUNT;
        end else begin
            eff_count = count_reg;
        end
        last = {1'b0, counter_reg} >= (eff_count - 6'd1);
    end

    assign emits    = !(granule_reg == sfs_pkg::GRN_FIRST || granule_reg == sfs_pkg::GRN_SECOND);
    assign in_ready = !emits || !m_valid_reg || m_ready;
    assign fire     = in_valid && in_ready;

    always_comb begin
        granule_next = granule_reg;
        held_a_next  = held_a_reg;
        held_b_next  = held_b_reg;
        counter_next = counter_reg;
        count_next   = cfg_wr_en ? cfg_wr_data : count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        subband_next = subband_reg;
        sf0_next     = sf0_reg;
        sf1_next     = sf1_reg;
        sf2_next     = sf2_reg;
        code_next    = code_reg;
        last_next    = last_reg;
        if (fire) begin
            unique case (granule_reg)
                sfs_pkg::GRN_FIRST: begin
                    held_a_next  = idx;
                    granule_next = sfs_pkg::GRN_SECOND;
                end
                sfs_pkg::GRN_SECOND: begin
                    held_b_next  = idx;
                    granule_next = sfs_pkg::GRN_THIRD;
                end
                default: begin
                    granule_next = sfs_pkg::GRN_FIRST;
                    m_valid_next = 1'b1;
                    subband_next = counter_reg;
                    sf0_next     = s0;
                    sf1_next     = s1;
                    sf2_next     = s2;
                    code_next    = code;
                    last_next    = last;
                    counter_next = last ? '0 : counter_reg + 5'd1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            granule_reg <= sfs_pkg::GRN_FIRST;
            held_a_reg  <= '0;
            held_b_reg  <= '0;
            counter_reg <= '0;
            count_reg   <= sfs_pkg::SUBBAND_COUNT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            granule_reg <= granule_next;
            held_a_reg  <= held_a_next;
            held_b_reg  <= held_b_next;
            counter_reg <= counter_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        subband_reg <= subband_next;
        sf0_reg     <= sf0_next;
        sf1_reg     <= sf1_next;
        sf2_reg     <= sf2_next;
        code_reg    <= code_next;
        last_reg    <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_subband      = subband_reg;
    assign m_sf_first     = sf0_reg;
    assign m_sf_second    = sf1_reg;
    assign m_sf_third     = sf2_reg;
    assign m_select_code  = code_reg;
    assign m_last_subband = last_reg;

endmodule

// ----- hw/rtl/scale_factor_select_unit.sv -----
// scale factor select unit: top level, lanes, max merge, index and pattern stages
// depends on sfs_pkg, sfs_lane, sfs_max_merge, sfs_index, sfs_pattern
//
// Takes one granule (12 samples of a subband) per clock and returns one result
// for every third granule: three scale factor indices, the transmission pattern
// code and the subband number. A granule passes twelve magnitude lanes, a
// 12-input compare tree, the msb search with three threshold compares and the
// pattern logic, each ending in a register. Every stage has its own valid and
// ready, so up to five more granules enter while a result waits on m_ready; the
// rate is one granule per cycle while m_ready does not stall, set by the compare
// tree and threshold compares. The user must write subband_count through
// cfg_wr_en/cfg_wr_data while no granule is in flight; nothing enforces it.
module scale_factor_select_unit #(
    parameter int SAMPLE_BITS = sfs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [sfs_pkg::COUNT_BITS-1:0]   cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_0,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_1,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_2,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_3,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_4,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_5,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_6,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_7,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_8,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_9,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_10,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_11,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sfs_pkg::SUBBAND_BITS-1:0] m_subband,
    output logic [sfs_pkg::SF_BITS-1:0]      m_sf_first,
    output logic [sfs_pkg::SF_BITS-1:0]      m_sf_second,
    output logic [sfs_pkg::SF_BITS-1:0]      m_sf_third,
    output logic [1:0]                       m_select_code,
    output logic                             m_last_subband
);

    logic signed [SAMPLE_BITS-1:0] samples [sfs_pkg::NUM_SAMPLES];
    logic        [SAMPLE_BITS-1:0] mags    [sfs_pkg::NUM_SAMPLES];
    logic                          lane_valid_reg;
    logic                          lane_valid_next;
    logic                          lane_ready;
    logic                          lane_load;
    logic                          merge_ready;
    logic                          merge_valid;
    logic [SAMPLE_BITS-1:0]        vmax;
    logic                          index_ready;
    logic                          index_valid;
    logic [sfs_pkg::SF_BITS-1:0]   idx;
    logic                          pattern_ready;

    assign samples[0]  = s_sample_0;
    assign samples[1]  = s_sample_1;
    assign samples[2]  = s_sample_2;
    assign samples[3]  = s_sample_3;
    assign samples[4]  = s_sample_4;
    assign samples[5]  = s_sample_5;
    assign samples[6]  = s_sample_6;
    assign samples[7]  = s_sample_7;
    assign samples[8]  = s_sample_8;
    assign samples[9]  = s_sample_9;
    assign samples[10] = s_sample_10;
    assign samples[11] = s_sample_11;

    assign lane_ready      = !lane_valid_reg || merge_ready;
    assign lane_load       = s_valid && lane_ready;
    assign lane_valid_next = lane_ready ? s_valid : lane_valid_reg;
    assign s_ready         = lane_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_valid_reg <= 1'b0;
        end else begin
            lane_valid_reg <= lane_valid_next;
        end
    end

    for (genvar g = 0; g < sfs_pkg::NUM_SAMPLES; g++) begin : g_lane
        sfs_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .aclk   (aclk),
            .load   (lane_load),
            .sample (samples[g]),
            .mag    (mags[g])
        );
    end

    sfs_max_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_max_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lane_valid_reg),
        .in_ready  (merge_ready),
        .mag       (mags),
        .out_valid (merge_valid),
        .out_ready (index_ready),
        .vmax      (vmax)
    );

    sfs_index #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_index (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (merge_valid),
        .in_ready  (index_ready),
        .vmax      (vmax),
        .out_valid (index_valid),
        .out_ready (pattern_ready),
        .idx       (idx)
    );

    sfs_pattern u_pattern (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (index_valid),
        .in_ready       (pattern_ready),
        .idx            (idx),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_subband      (m_subband),
        .m_sf_first     (m_sf_first),
        .m_sf_second    (m_sf_second),
        .m_sf_third     (m_sf_third),
        .m_select_code  (m_select_code),
        .m_last_subband (m_last_subband)
    );

endmodule

// ----- tb/tb_scale_factor_select_unit.sv -----
// self-checking testbench for scale_factor_select_unit: granules go in over a valid/ready
// channel, results are checked against an in-bench scale factor and pattern predictor
// depends on sfs_pkg and scale_factor_select_unit
`timescale 1ns / 1ps

module tb_scale_factor_select_unit;

    localparam int SAMPLE_W = sfs_pkg::SAMPLE_BITS_DEF;
    localparam int unsigned FULL_SCALE = 1 << (SAMPLE_W - 1);
    localparam int DRAIN_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT = 50;

    typedef logic [sfs_pkg::NUM_SAMPLES-1:0][SAMPLE_W-1:0] samples_t;

    typedef struct packed {
        logic [sfs_pkg::SUBBAND_BITS-1:0] subband;
        logic [sfs_pkg::SF_BITS-1:0]      sf_first;
        logic [sfs_pkg::SF_BITS-1:0]      sf_second;
        logic [sfs_pkg::SF_BITS-1:0]      sf_third;
        sfs_pkg::sel_code_t               code;
        logic                             last;
    } factor_set_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [sfs_pkg::COUNT_BITS-1:0] cfg_wr_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_0 = '0, s_sample_1 = '0, s_sample_2 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_3 = '0, s_sample_4 = '0, s_sample_5 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_6 = '0, s_sample_7 = '0, s_sample_8 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_9 = '0, s_sample_10 = '0, s_sample_11 = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [sfs_pkg::SUBBAND_BITS-1:0] m_subband;
    logic [sfs_pkg::SF_BITS-1:0]      m_sf_first;
    logic [sfs_pkg::SF_BITS-1:0]      m_sf_second;
    logic [sfs_pkg::SF_BITS-1:0]      m_sf_third;
    logic [1:0]              m_select_code;
    logic                    m_last_subband;

    // predictor state
    sfs_pkg::granule_t              grn_phase = sfs_pkg::GRN_FIRST;
    logic [sfs_pkg::SF_BITS-1:0]    held_first = '0;
    logic [sfs_pkg::SF_BITS-1:0]    held_second = '0;
    logic [sfs_pkg::SUBBAND_BITS-1:0] band_ctr = '0;
    logic [sfs_pkg::COUNT_BITS-1:0] band_count = sfs_pkg::SUBBAND_COUNT_RESET;

    factor_set_t expected_factors[$];
    int          mismatches = 0;
    int          granules_seen = 0;
    int          results_seen = 0;
    int          code_tally[4] = '{0, 0, 0, 0};
    int          quiet_cycles = 0;
    bit          steady_flow = 1'b0;

    scale_factor_select_unit #(
        .SAMPLE_BITS(SAMPLE_W)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_sample_0(s_sample_0),
        .s_sample_1(s_sample_1),
        .s_sample_2(s_sample_2),
        .s_sample_3(s_sample_3),
        .s_sample_4(s_sample_4),
        .s_sample_5(s_sample_5),
        .s_sample_6(s_sample_6),
        .s_sample_7(s_sample_7),
        .s_sample_8(s_sample_8),
        .s_sample_9(s_sample_9),
        .s_sample_10(s_sample_10),
        .s_sample_11(s_sample_11),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_subband(m_subband),
        .m_sf_first(m_sf_first),
        .m_sf_second(m_sf_second),
        .m_sf_third(m_sf_third),
        .m_select_code(m_select_code),
        .m_last_subband(m_last_subband)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // threshold i is 2^((3-i)/3) * 2^20, floored at 1
    function automatic int unsigned threshold_at(input int i);
        int unsigned octave_top;
        int unsigned v;
        case (i % 3)
            0: octave_top = 2097152;
            1: octave_top = 1664510;
            default: octave_top = 1321122;
        endcase
        v = octave_top >> (i / 3);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic logic [sfs_pkg::SF_BITS-1:0] scale_index(input int unsigned peak);
        int msb;
        int idx;
        int unsigned t;
        if (peak == 0) begin
            return sfs_pkg::SF_SILENT;
        end
        msb = 0;
        t = peak;
        while (t > 1) begin
            t = t >> 1;
            msb++;
        end
        idx = (21 - msb) * 3 - 3;
        if (idx < 0) begin
            return sfs_pkg::SF_LOUDEST;
        end
        while (idx < 63 && peak <= threshold_at(idx + 1)) begin
            idx++;
        end
        return idx[sfs_pkg::SF_BITS-1:0];
    endfunction

    function automatic sfs_pkg::diff_class_t step_class(input logic [sfs_pkg::SF_BITS-1:0] a,
                                                        input logic [sfs_pkg::SF_BITS-1:0] b);
        int d;
        d = int'(a) - int'(b);
        if (d <= -3) begin
            return sfs_pkg::CLS_DOWN_FAR;
        end else if (d < 0) begin
            return sfs_pkg::CLS_DOWN_NEAR;
        end else if (d == 0) begin
            return sfs_pkg::CLS_EQUAL;
        end else if (d < 3) begin
            return sfs_pkg::CLS_UP_NEAR;
        end
        return sfs_pkg::CLS_UP_FAR;
    endfunction

    task automatic predict_granule(input samples_t g);
        int unsigned peak;
        int          v;
        logic [sfs_pkg::SF_BITS-1:0] idx;
        logic [sfs_pkg::SF_BITS-1:0] sf0, sf1, sf2;
        sfs_pkg::diff_class_t c1, c2;
        sfs_pkg::sel_code_t   code;
        int unsigned eff;
        factor_set_t f;
        peak = 0;
        for (int k = 0; k < sfs_pkg::NUM_SAMPLES; k++) begin
            v = int'($signed(g[k]));
            if (v < 0) begin
                v = -v;
            end
            if (v > peak) begin
                peak = v;
            end
        end
        granules_seen++;
        idx = scale_index(peak);
        case (grn_phase)
            sfs_pkg::GRN_FIRST: begin
                held_first = idx;
                grn_phase = sfs_pkg::GRN_SECOND;
            end
            sfs_pkg::GRN_SECOND: begin
                held_second = idx;
                grn_phase = sfs_pkg::GRN_THIRD;
            end
            default: begin
                grn_phase = sfs_pkg::GRN_FIRST;
                sf0 = held_first;
                sf1 = held_second;
                sf2 = idx;
                c1 = step_class(sf0, sf1);
                c2 = step_class(sf1, sf2);
                case ({c1, c2})
                    {sfs_pkg::CLS_DOWN_FAR, sfs_pkg::CLS_DOWN_NEAR},
                    {sfs_pkg::CLS_DOWN_FAR, sfs_pkg::CLS_EQUAL},
                    {sfs_pkg::CLS_UP_FAR, sfs_pkg::CLS_DOWN_NEAR},
                    {sfs_pkg::CLS_UP_FAR, sfs_pkg::CLS_EQUAL}: begin
                        code = sfs_pkg::SEL_LAST_TWO;
                        sf2 = sf1;
                    end
                    {sfs_pkg::CLS_DOWN_FAR, sfs_pkg::CLS_UP_NEAR},
                    {sfs_pkg::CLS_UP_FAR, sfs_pkg::CLS_UP_NEAR}: begin
                        code = sfs_pkg::SEL_LAST_TWO;
                        sf1 = sf2;
                    end
                    {sfs_pkg::CLS_DOWN_NEAR, sfs_pkg::CLS_DOWN_FAR},
                    {sfs_pkg::CLS_DOWN_NEAR, sfs_pkg::CLS_UP_FAR},
                    {sfs_pkg::CLS_EQUAL, sfs_pkg::CLS_UP_FAR}: begin
                        code = sfs_pkg::SEL_FIRST_TWO;
                        sf1 = sf0;
                    end
                    {sfs_pkg::CLS_DOWN_NEAR, sfs_pkg::CLS_DOWN_NEAR},
                    {sfs_pkg::CLS_DOWN_NEAR, sfs_pkg::CLS_EQUAL},
                    {sfs_pkg::CLS_EQUAL, sfs_pkg::CLS_DOWN_FAR},
                    {sfs_pkg::CLS_EQUAL, sfs_pkg::CLS_DOWN_NEAR},
                    {sfs_pkg::CLS_EQUAL, sfs_pkg::CLS_EQUAL}: begin
                        code = sfs_pkg::SEL_ONE;
                        sf1 = sf0;
                        sf2 = sf0;
                    end
                    {sfs_pkg::CLS_EQUAL, sfs_pkg::CLS_UP_NEAR},
                    {sfs_pkg::CLS_UP_NEAR, sfs_pkg::CLS_UP_NEAR}: begin
                        code = sfs_pkg::SEL_ONE;
                        sf0 = sf2;
                        sf1 = sf2;
                    end
                    {sfs_pkg::CLS_UP_NEAR, sfs_pkg::CLS_DOWN_FAR},
                    {sfs_pkg::CLS_UP_NEAR, sfs_pkg::CLS_DOWN_NEAR},
                    {sfs_pkg::CLS_UP_NEAR, sfs_pkg::CLS_EQUAL}: begin
                        code = sfs_pkg::SEL_ONE;
                        sf0 = sf1;
                        sf2 = sf1;
                    end
                    {sfs_pkg::CLS_DOWN_NEAR, sfs_pkg::CLS_UP_NEAR}: begin
                        // dip in the middle: keep the smaller outer index
                        code = sfs_pkg::SEL_ONE;
                        if (sf0 > sf2) begin
                            sf0 = sf2;
                        end
                        sf1 = sf0;
                        sf2 = sf0;
                    end
                    default: begin
                        code = sfs_pkg::SEL_ALL;
                    end
                endcase
                eff = band_count;
                if (eff == 0 || eff > sfs_pkg::MAX_SUBBANDS) begin
                    eff = sfs_pkg::MAX_SUBBANDS;
                end
                f.subband = band_ctr;
                f.sf_first = sf0;
                f.sf_second = sf1;
                f.sf_third = sf2;
                f.code = code;
                f.last = (32'(band_ctr) >= eff - 1);
                expected_factors.push_back(f);
                code_tally[code]++;
                band_ctr = f.last ? '0 : band_ctr + 1'b1;
            end
        endcase
    endtask

    task automatic report_error(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want, input int band);
        if (got !== want) begin
            report_error($sformatf("subband %0d %s: got %0d, expected %0d",
                                   band, name, got, want));
        end
    endtask

    // result check first, then prediction of any granule taken at the same edge
    always @(posedge aclk) begin
        factor_set_t want;
        samples_t    taken;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_factors.size() == 0) begin
                    report_error($sformatf("result transfer for subband %0d with none pending",
                                           m_subband));
                end else begin
                    want = expected_factors.pop_front();
                    check_field("subband", 8'(m_subband), 8'(want.subband),
                                int'(want.subband));
                    check_field("sf_first", 8'(m_sf_first), 8'(want.sf_first),
                                int'(want.subband));
                    check_field("sf_second", 8'(m_sf_second), 8'(want.sf_second),
                                int'(want.subband));
                    check_field("sf_third", 8'(m_sf_third), 8'(want.sf_third),
                                int'(want.subband));
                    check_field("select_code", 8'(m_select_code), 8'(want.code),
                                int'(want.subband));
                    check_field("last_subband", 8'(m_last_subband), 8'(want.last),
                                int'(want.subband));
                end
            end
            if (s_valid && s_ready) begin
                taken = {s_sample_11, s_sample_10, s_sample_9, s_sample_8,
                         s_sample_7, s_sample_6, s_sample_5, s_sample_4,
                         s_sample_3, s_sample_2, s_sample_1, s_sample_0};
                predict_granule(taken);
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(0, 99) >= 21);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_scale_factor_select_unit failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one sample at +/-peak, the rest anywhere within that magnitude
    function automatic samples_t granule_with_peak(input int unsigned peak, input bit negative);
        samples_t g;
        int       v;
        int       spot;
        for (int k = 0; k < sfs_pkg::NUM_SAMPLES; k++) begin
            v = int'($urandom_range(0, 2 * peak)) - int'(peak);
            if (v > int'(FULL_SCALE - 1)) begin
                v = int'(FULL_SCALE - 1);
            end
            g[k] = v[SAMPLE_W-1:0];
        end
        spot = $urandom_range(0, sfs_pkg::NUM_SAMPLES - 1);
        v = (negative || peak >= FULL_SCALE) ? -int'(peak) : int'(peak);
        g[spot] = v[SAMPLE_W-1:0];
        return g;
    endfunction

    function automatic samples_t noise_granule();
        samples_t    g;
        logic [31:0] r;
        for (int k = 0; k < sfs_pkg::NUM_SAMPLES; k++) begin
            r = $urandom;
            g[k] = r[SAMPLE_W-1:0];
        end
        return g;
    endfunction

    // peak that lands somewhere inside the band of index idx
    function automatic int unsigned peak_for_index(input int idx);
        int unsigned lo;
        int unsigned hi;
        if (idx >= 63) begin
            return $urandom_range(0, 1);
        end
        hi = threshold_at(idx);
        lo = threshold_at(idx + 1) + 1;
        if (hi < lo) begin
            return hi;
        end
        return $urandom_range(lo, hi);
    endfunction

    task automatic send_granule(input samples_t g);
        while (!steady_flow && $urandom_range(0, 99) < 21) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_0 <= g[0];
        s_sample_1 <= g[1];
        s_sample_2 <= g[2];
        s_sample_3 <= g[3];
        s_sample_4 <= g[4];
        s_sample_5 <= g[5];
        s_sample_6 <= g[6];
        s_sample_7 <= g[7];
        s_sample_8 <= g[8];
        s_sample_9 <= g[9];
        s_sample_10 <= g[10];
        s_sample_11 <= g[11];
        do @(posedge aclk); while (!s_ready);
    endtask

    // three granules of one subband, indices close together most of the time
    task automatic send_random_subband();
        int target;
        int pick;
        target = $urandom_range(0, 63);
        for (int g = 0; g < 3; g++) begin
            if (g > 0) begin
                if ($urandom_range(0, 99) < 70) begin
                    target = target + int'($urandom_range(0, 8)) - 4;
                end else begin
                    target = $urandom_range(0, 63);
                end
            end
            if (target < 0) begin
                target = 0;
            end
            if (target > 63) begin
                target = 63;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_granule(noise_granule());
            end else if (pick < 12) begin
                send_granule(granule_with_peak($urandom_range(1 << 21, FULL_SCALE), pick[0]));
            end else if (pick < 15) begin
                send_granule(granule_with_peak(0, 1'b0));
            end else begin
                send_granule(granule_with_peak(peak_for_index(target), pick[0]));
            end
        end
    endtask

    task automatic settle_block();
        s_valid <= 1'b0;
        while (expected_factors.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_band_count(input logic [sfs_pkg::COUNT_BITS-1:0] value);
        settle_block();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        band_count = value;
    endtask

    // silence, overrun, smallest magnitudes, exact thresholds and the pattern rules
    task automatic test_boundary_granules();
        int unsigned peaks[24];
        peaks = '{0, 0, 0,
                  FULL_SCALE, FULL_SCALE - 1, 1 << 21,
                  1, 1 << 20, (1 << 20) + 1,
                  threshold_at(10), threshold_at(11), threshold_at(10),
                  threshold_at(20), threshold_at(20), threshold_at(20),
                  threshold_at(12), threshold_at(13), threshold_at(30),
                  threshold_at(40), threshold_at(30), threshold_at(30),
                  threshold_at(5), threshold_at(15), threshold_at(25)};
        for (int k = 0; k < 24; k++) begin
            send_granule(granule_with_peak(peaks[k], k[0]));
        end
    endtask

    task automatic test_single_subband();
        write_band_count(6'd1);
        repeat (6) send_random_subband();
    endtask

    // a zero count behaves as the full 32 subbands
    task automatic test_zero_count_wrap();
        write_band_count(6'd0);
        repeat (33) send_random_subband();
    endtask

    // shrink the count below the running counter, then an oversize count
    task automatic test_count_below_counter();
        write_band_count(6'd32);
        repeat (20) send_random_subband();
        write_band_count(6'd8);
        repeat (3) send_random_subband();
        write_band_count(6'd63);
        repeat (4) send_random_subband();
    endtask

    task automatic test_random_traffic();
        logic [sfs_pkg::COUNT_BITS-1:0] counts[7];
        counts = '{6'd1, 6'd32, 6'd0, 6'd63,
                   sfs_pkg::COUNT_BITS'($urandom_range(1, sfs_pkg::MAX_SUBBANDS)),
                   sfs_pkg::COUNT_BITS'($urandom_range(sfs_pkg::MAX_SUBBANDS + 1, 62)),
                   sfs_pkg::COUNT_BITS'($urandom_range(0, 63))};
        for (int p = 0; p < 7; p++) begin
            write_band_count(counts[p]);
            steady_flow = (p == 2);
            repeat (50) send_random_subband();
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_boundary_granules();
        test_single_subband();
        test_zero_count_wrap();
        test_count_below_counter();
        test_random_traffic();
        settle_block();
        $display("%0d granules, %0d results, %0d mismatches", granules_seen, results_seen,
                 mismatches);
        $display("patterns all/first-two/one/last-two: %0d/%0d/%0d/%0d",
                 code_tally[sfs_pkg::SEL_ALL], code_tally[sfs_pkg::SEL_FIRST_TWO],
                 code_tally[sfs_pkg::SEL_ONE], code_tally[sfs_pkg::SEL_LAST_TWO]);
        if (mismatches == 0) begin
            $display("tb_scale_factor_select_unit passed");
        end else begin
            $display("tb_scale_factor_select_unit failed");
        end
        $finish;
    end

endmodule
